### rtl/hrb_pkg.sv
// hrb_pkg: shared constants, types and state codes of the history ring buffer
// no dependencies

package hrb_pkg;

  localparam int RING_BYTES_DEF = 4096;
  localparam int MAX_READ_DEF   = 64;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 64;
  localparam int CNT_W  = 7;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic ST_BYTE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SIZE,
    S_RUN
  } hrb_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              status;
    logic              is_last;
  } hrb_word_t;

  typedef struct packed {
    logic      push;
    hrb_word_t word;
  } hrb_push_t;

endpackage

### rtl/hrb_if.sv
// hrb_in_if / hrb_out_if: valid-ready channels of the history ring buffer
// depends on hrb_pkg

interface hrb_in_if import hrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  read_count;

  modport source (output valid, action, data_byte, position, read_count, input ready);
  modport sink   (input valid, action, data_byte, position, read_count, output ready);
endinterface

interface hrb_out_if import hrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              status;
  logic              is_last;
  logic [POS_W-1:0]  write_position;
  logic [POS_W-1:0]  oldest_position;

  modport source (output valid, read_byte, status, is_last, write_position,
                  oldest_position, input ready);
  modport sink   (input valid, read_byte, status, is_last, write_position,
                  oldest_position, output ready);
endinterface

### rtl/hrb_out_fifo.sv
// hrb_out_fifo: two-word output register with skid slot
// depends on hrb_pkg

module hrb_out_fifo import hrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hrb_push_t push_i,
  input  logic      pop_i,
  output hrb_word_t head_o,
  output logic      valid_o,
  output logic [1:0] held_o
);

  hrb_word_t  s0_r, s0_nxt;
  hrb_word_t  s1_r, s1_nxt;
  logic [1:0] held_r, held_nxt;

  always_comb begin
    s0_nxt   = s0_r;
    s1_nxt   = s1_r;
    held_nxt = held_r;
    unique case (held_r)
      2'd0: begin
        if (push_i.push) begin
          s0_nxt   = push_i.word;
          held_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push_i.push && pop_i) begin
          s0_nxt = push_i.word;
        end else if (push_i.push) begin
          s1_nxt   = push_i.word;
          held_nxt = 2'd2;
        end else if (pop_i) begin
          held_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop_i) begin
          s0_nxt = s1_r;
          if (push_i.push) begin
            s1_nxt = push_i.word;
          end else begin
            held_nxt = 2'd1;
          end
        end
      end
      default: begin
        held_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign head_o  = s0_r;
  assign valid_o = (held_r != 2'd0);
  assign held_o  = held_r;

endmodule

### rtl/history_ring_buffer.sv
// history_ring_buffer: byte history ring addressed by absolute stream position
// a write goes into the ram when accepted; a read steps through S_CHECK, S_SIZE, the ram
//   read register and the output fifo (an empty result is pushed from S_SIZE); one write
//   per cycle and one read byte per cycle if not stalled; input held until output drains
// reset: synchronous, clears positions and control; ram entries are written before read
// depends on hrb_pkg, hrb_in_if, hrb_out_if, hrb_out_fifo

module history_ring_buffer import hrb_pkg::*; #(
  parameter int RING_BYTES = RING_BYTES_DEF,
  parameter int MAX_READ   = MAX_READ_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hrb_in_if.sink    in_ch,
  hrb_out_if.source out_ch
);

  localparam int AW = $clog2(RING_BYTES);
  localparam logic [POS_W-1:0] CAP      = POS_W'(RING_BYTES);
  localparam logic [POS_W-1:0] CAP_M1   = POS_W'(RING_BYTES - 1);
  localparam logic [CNT_W-1:0] MAX_RD   = CNT_W'(MAX_READ);

  logic [BYTE_W-1:0] ring_mem [RING_BYTES];

  hrb_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  tw_r, old_r, pos_r, diff_r;
  logic [CNT_W-1:0]  cnt_r, rem_r, len;
  logic [AW-1:0]     addr_r;
  logic              bad_r;
  logic              rd_vld_r, rd_last_r;
  logic [BYTE_W-1:0] rd_data_r;

  logic      in_acc, wr_en, rd_acc, empty_push, issue, issue_ok, pop;
  logic [1:0] held, occ;
  hrb_push_t push;
  hrb_word_t head;
  logic      head_vld;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign wr_en  = in_acc && (in_ch.action == ACT_WRITE);
  assign rd_acc = in_acc && (in_ch.action == ACT_READ);
  assign pop    = out_ch.valid && out_ch.ready;

  assign len = (diff_r < {{(POS_W-CNT_W){1'b0}}, cnt_r}) ? diff_r[CNT_W-1:0] : cnt_r;
  assign occ = held + {1'b0, rd_vld_r};
  assign issue_ok = (occ < 2'd2) || ((occ == 2'd2) && pop);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (rd_acc) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_SIZE;
      S_SIZE: begin
        if (bad_r || (len == '0)) state_nxt = S_IDLE;
        else                      state_nxt = S_RUN;
      end
      S_RUN:   if (issue_ok && (rem_r == CNT_W'(1))) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    empty_push  = 1'b0;
    issue       = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready = (held == 2'd0) && !rd_vld_r;
      S_CHECK: ;
      S_SIZE:  empty_push = bad_r || (len == '0);
      S_RUN:   issue = issue_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tw_r     <= '0;
      old_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (wr_en) begin
        tw_r <= tw_r + POS_W'(1);
        if ((tw_r >= CAP) && (tw_r != '1)) begin
          old_r <= tw_r - CAP_M1;
        end else begin
          old_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      pos_r <= in_ch.position;
      cnt_r <= (in_ch.read_count > MAX_RD) ? MAX_RD : in_ch.read_count;
    end
    if (state_r == S_CHECK) begin
      bad_r  <= (pos_r < old_r) || (pos_r > tw_r);
      diff_r <= tw_r - pos_r;
    end
    if (state_r == S_SIZE) begin
      rem_r  <= len;
      addr_r <= pos_r[AW-1:0];
    end
    if (issue) begin
      rem_r     <= rem_r - CNT_W'(1);
      addr_r    <= addr_r + AW'(1);
      rd_last_r <= (rem_r == CNT_W'(1));
    end
  end

  // ring ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tw_r[AW-1:0]] <= in_ch.data_byte;
    end
    if (issue) begin
      rd_data_r <= ring_mem[addr_r];
    end
  end

  always_comb begin
    push.push = empty_push || rd_vld_r;
    if (rd_vld_r) begin
      push.word.read_byte = rd_data_r;
      push.word.status    = ST_BYTE;
      push.word.is_last   = rd_last_r;
    end else begin
      push.word.read_byte = '0;
      push.word.status    = ST_EMPTY;
      push.word.is_last   = 1'b1;
    end
  end

  hrb_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_vld),
    .held_o  (held)
  );

  assign out_ch.valid           = head_vld;
  assign out_ch.read_byte       = head.read_byte;
  assign out_ch.status          = head.status;
  assign out_ch.is_last         = head.is_last;
  assign out_ch.write_position  = tw_r;
  assign out_ch.oldest_position = old_r;

endmodule

### rtl/hrb_checker.sv
// hrb_checker: port-level assertions for the history ring buffer, bound to the top level
// depends on hrb_pkg and history_ring_buffer

module hrb_checker import hrb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic              out_status,
  input logic              out_is_last,
  input logic [POS_W-1:0]  out_write_position,
  input logic [POS_W-1:0]  out_oldest_position
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte)
      && $stable(out_status) && $stable(out_is_last))
    else $error("output word changed while stalled");

  // no new word taken while results are pending
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while output pending");

  // empty result is a single zero word
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_read_byte == '0) && out_is_last)
    else $error("empty result malformed");

  // positions stay fixed while a read streams out
  a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=>
      $stable(out_write_position) && $stable(out_oldest_position))
    else $error("positions moved during a read");

endmodule

bind history_ring_buffer hrb_checker u_hrb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_read_byte       (out_ch.read_byte),
  .out_status          (out_ch.status),
  .out_is_last         (out_ch.is_last),
  .out_write_position  (out_ch.write_position),
  .out_oldest_position (out_ch.oldest_position)
);

### dv/tb_history_ring_buffer.sv
// tb_history_ring_buffer: self-checking bench for the history ring buffer
// drives byte appends and windowed reads with random idling, checks every output word
// depends on hrb_pkg, hrb_in_if, hrb_out_if and the history_ring_buffer rtl
`timescale 1ns / 100ps

module tb_history_ring_buffer;
  import hrb_pkg::*;

  localparam int RING  = RING_BYTES_DEF;
  localparam int IDX_W = $clog2(RING);

  typedef struct {
    hrb_word_t        word;
    logic [POS_W-1:0] wr_mark;
    logic [POS_W-1:0] oldest_pos;
  } hist_word_t;

  class ring_window_check;
    logic [BYTE_W-1:0] shadow [RING];
    logic [POS_W-1:0]  written;
    hist_word_t        due_words [$];
    int unsigned       mismatches;

    function new();
      foreach (shadow[i]) shadow[i] = '0;
      written    = '0;
      mismatches = 0;
    endfunction

    function logic [POS_W-1:0] oldest();
      return (written > POS_W'(RING)) ? written - POS_W'(RING) : '0;
    endfunction

    function void queue_word(logic [BYTE_W-1:0] b, logic st, logic last);
      hist_word_t w;
      w.word.read_byte = b;
      w.word.status    = st;
      w.word.is_last   = last;
      w.wr_mark        = written;
      w.oldest_pos     = oldest();
      due_words.push_back(w);
    endfunction

    function void take_word(logic act, logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos,
                            logic [CNT_W-1:0] cnt);
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] n;
      logic [POS_W-1:0] k;
      logic [POS_W-1:0] at;
      if (act == ACT_WRITE) begin
        shadow[written[IDX_W-1:0]] = b;
        written = written + 1;
      end else begin
        lo = oldest();
        n  = (pos < lo || pos > written) ? '0 : written - pos;
        if (n > POS_W'(cnt)) n = POS_W'(cnt);
        if (n > POS_W'(MAX_READ_DEF)) n = POS_W'(MAX_READ_DEF);
        if (n == 0) begin
          queue_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < n; k++) begin
            at = pos + k;
            queue_word(shadow[at[IDX_W-1:0]], ST_BYTE, k == n - 1);
          end
        end
      end
    endfunction

    function void match_word(hrb_word_t got, logic [POS_W-1:0] wp, logic [POS_W-1:0] op);
      hist_word_t e;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %h status %b last %b wp %0d oldest %0d",
                   got.read_byte, got.status, got.is_last, wp, op);
      end else begin
        e = due_words.pop_front();
        if (e.word !== got || e.wr_mark !== wp || e.oldest_pos !== op) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp byte %h status %b last %b wp %0d oldest %0d",
                     e.word.read_byte, e.word.status, e.word.is_last, e.wr_mark,
                     e.oldest_pos);
            $display("          got byte %h status %b last %b wp %0d oldest %0d",
                     got.read_byte, got.status, got.is_last, wp, op);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   in_idle_en = 1'b1;
  bit   out_idle_en = 1'b1;
  int   hold_left = 0;

  ring_window_check sb = new();

  hrb_in_if  in_if ();
  hrb_out_if out_if ();

  history_ring_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (out_idle_en && $urandom_range(0, 11) == 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.match_word({out_if.read_byte, out_if.status, out_if.is_last},
                    out_if.write_position, out_if.oldest_position);
  end

  task automatic push_word(input logic act, input logic [BYTE_W-1:0] b,
                           input logic [POS_W-1:0] pos, input logic [CNT_W-1:0] cnt);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.data_byte  <= b;
    in_if.position   <= pos;
    in_if.read_count <= cnt;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.take_word(act, b, pos, cnt);
    @(negedge clk);
  endtask

  task automatic mixed_burst(input int n, input int read_pct);
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] wp;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    int unsigned      span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) > read_pct) begin
        push_word(ACT_WRITE, BYTE_W'($urandom), {$urandom, $urandom}, CNT_W'($urandom));
      end else begin
        wp   = sb.written;
        lo   = sb.oldest();
        span = int'(wp - lo);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pos = lo + $urandom_range(0, span);
          4, 5:       pos = wp - $urandom_range(0, span < 70 ? span : 70);
          6:          pos = wp;
          7:          pos = wp + $urandom_range(1, 100);
          8:          pos = (lo != 0) ? lo - $urandom_range(1, lo < 100 ? int'(lo) : 100)
                                      : {$urandom, $urandom};
          default:    pos = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
          0:       cnt = '0;
          1:       cnt = CNT_W'($urandom_range(MAX_READ_DEF + 1, 127));
          2:       cnt = CNT_W'(MAX_READ_DEF);
          default: cnt = CNT_W'($urandom_range(1, MAX_READ_DEF));
        endcase
        push_word(ACT_READ, BYTE_W'($urandom), pos, cnt);
      end
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.action     = ACT_WRITE;
    in_if.data_byte  = '0;
    in_if.position   = '0;
    in_if.read_count = '0;
    out_if.ready     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring: nothing to read, future and far-away positions; then six byte appends
    push_word(ACT_READ, 8'h00, 64'd0, 7'd5);
    push_word(ACT_READ, 8'h00, 64'd1, 7'd1);
    push_word(ACT_READ, 8'hFF, '1, 7'd127);
    push_word(ACT_READ, 8'h00, 64'h8000_0000_0000_0000, 7'd64);
    push_word(ACT_WRITE, 8'h00, '1, 7'd127);
    push_word(ACT_WRITE, 8'hFF, 64'd0, 7'd0);
    push_word(ACT_WRITE, 8'hA5, 64'd3, 7'd9);
    push_word(ACT_WRITE, 8'h5A, 64'd0, 7'd0);
    push_word(ACT_WRITE, 8'h01, 64'd0, 7'd0);
    push_word(ACT_WRITE, 8'h80, 64'd0, 7'd0);
    // zero count, oversized count, partial and edge reads
    push_word(ACT_READ, 8'h00, 64'd0, 7'd0);
    push_word(ACT_READ, 8'h00, 64'd0, 7'd127);
    push_word(ACT_READ, 8'h00, 64'd0, 7'd64);
    push_word(ACT_READ, 8'h00, 64'd5, 7'd1);
    push_word(ACT_READ, 8'h00, 64'd2, 7'd2);
    push_word(ACT_READ, 8'h00, 64'd6, 7'd3);
    push_word(ACT_READ, 8'h00, 64'd7, 7'd1);
    push_word(ACT_READ, 8'h00, 64'd3, 7'd65);

    mixed_burst(320, 40);

    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    mixed_burst(80, 40);
    in_if.valid <= 1'b0;

    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_words.size() == 0)
      $display("tb_history_ring_buffer passed");
    else
      $display("tb_history_ring_buffer failed");
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("tb_history_ring_buffer failed");
    $finish;
  end

endmodule

### history_ring_buffer.f
rtl/hrb_pkg.sv
rtl/hrb_if.sv
rtl/hrb_out_fifo.sv
rtl/history_ring_buffer.sv
rtl/hrb_checker.sv
dv/tb_history_ring_buffer.sv
